@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of the trie dictionary.
// Depends on nets named clock and reset in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset
`define ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/tdict_pkg.sv @@
// Shared constants and types of the trie dictionary: op and status codes,
// field widths and parameter defaults. No dependencies.
`default_nettype none

package tdict_pkg;

   // Parameter defaults
   localparam int DEF_ALPHABET_SIZE = 58;
   localparam int DEF_NODE_COUNT    = 1024;

   // Field widths
   localparam int OP_W     = 2;
   localparam int SYMBOL_W = 8;
   localparam int STATUS_W = 2;

   // First valid key character ('A')
   localparam logic [SYMBOL_W-1:0] FIRST_SYMBOL = 8'd65;

   // Operation codes; the unused code behaves as search
   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_POOL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

   // One result item
   typedef struct packed {
      logic                done_res;
      logic                answer;
      logic [STATUS_W-1:0] status;
   } result_type;

endpackage

`default_nettype wire

@@ rtl/tdict_ram.sv @@
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data. No dependencies.
`default_nettype none

module tdict_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 1
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, data registered
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/tdict_ctrl.sv @@
// Sequencer of the trie dictionary: walk registers, node allocation,
// clearing pass, result register. Uses tdict_pkg; drives both RAMs.
`default_nettype none

module tdict_ctrl import tdict_pkg::*; #(
   parameter int ALPHABET_SIZE = DEF_ALPHABET_SIZE,
   parameter int NODE_COUNT    = DEF_NODE_COUNT,
   localparam int SLOT_COUNT   = NODE_COUNT * ALPHABET_SIZE,
   localparam int SLOT_W       = $clog2(SLOT_COUNT),
   localparam int NODE_W       = $clog2(NODE_COUNT)
) (
   input  wire logic                clock,
   input  wire logic                reset,
   // item input
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [OP_W-1:0]     req_op,
   input  wire logic [SYMBOL_W-1:0] req_symbol,
   input  wire logic                req_last,
   input  wire logic                req_empty_key,
   // result output
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic                     rsp_done_res,
   output logic                     rsp_answer,
   output logic [STATUS_W-1:0]      rsp_status,
   // child link RAM
   output logic                     link_we,
   output logic [SLOT_W-1:0]        link_waddr,
   output logic [NODE_W-1:0]        link_wdata,
   output logic [SLOT_W-1:0]        link_raddr,
   input  wire logic [NODE_W-1:0]   link_rdata,
   // end mark RAM
   output logic                     mark_we,
   output logic [NODE_W-1:0]        mark_waddr,
   output logic                     mark_wdata,
   output logic [NODE_W-1:0]        mark_raddr,
   input  wire logic                mark_rdata
);

   localparam int FREE_W = $clog2(NODE_COUNT + 1);

   typedef enum logic [4:0] {
      S_CLEAR = 5'b00001,
      S_IDLE  = 5'b00010,
      S_LINK  = 5'b00100,
      S_MARK  = 5'b01000,
      S_EMIT  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // walk state
   logic [NODE_W-1:0] cur_node_ff, cur_node_in;
   logic [SLOT_W-1:0] node_base_ff, node_base_in;
   logic [FREE_W-1:0] next_free_ff, next_free_in;
   logic              walk_failed_ff, walk_failed_in;
   logic [SLOT_W-1:0] clr_ff, clr_in;

   // item being worked on
   logic [OP_W-1:0]   op_ff, op_in;
   logic              last_ff, last_in;
   logic              range_bad_ff, range_bad_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [NODE_W-1:0] conc_node_ff, conc_node_in;

   // result register and pending result
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;
   result_type pend_ff, pend_in;

   logic              req_accept;
   logic              emit_ok;
   logic [8:0]        sym_diff;
   logic              sym_bad;
   logic [SLOT_W-1:0] idx_ext;
   logic [NODE_W-1:0] mul_node;
   logic [SLOT_W-1:0] mul_prod;
   logic              fin;
   result_type        fin_res;
   logic [NODE_W-1:0] node_nx;
   logic              fail_nx;
   logic [STATUS_W-1:0] st_nx;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign emit_ok    = !rsp_valid_ff || !rsp_stall;

   // Symbol range check and slot offset
   assign sym_diff = {1'b0, req_symbol} - {1'b0, FIRST_SYMBOL};
   assign sym_bad  = sym_diff[8] || (sym_diff >= 9'(ALPHABET_SIZE));
   assign idx_ext  = sym_bad ? '0 : SLOT_W'(sym_diff[7:0]);

   // Row base of the node the walk moves to
   assign mul_prod = SLOT_W'(SLOT_W'(mul_node) * SLOT_W'(ALPHABET_SIZE));

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      cur_node_in    = cur_node_ff;
      node_base_in   = node_base_ff;
      next_free_in   = next_free_ff;
      walk_failed_in = walk_failed_ff;
      clr_in         = clr_ff;
      op_in          = op_ff;
      last_in        = last_ff;
      range_bad_in   = range_bad_ff;
      slot_in        = slot_ff;
      conc_node_in   = conc_node_ff;
      pend_in        = pend_ff;

      link_we    = 1'b0;
      link_waddr = slot_ff;
      link_wdata = next_free_ff[NODE_W-1:0];
      link_raddr = node_base_ff + idx_ext;
      mark_we    = 1'b0;
      mark_waddr = conc_node_ff;
      mark_wdata = 1'b0;
      mark_raddr = '0;

      mul_node = link_rdata;
      node_nx  = cur_node_ff;
      fail_nx  = walk_failed_ff;
      st_nx    = ST_OK;
      fin      = 1'b0;
      fin_res  = '{done_res: 1'b0, answer: 1'b0, status: ST_OK};

      unique case (state_ff)
         S_CLEAR: begin
            link_we    = 1'b1;
            link_waddr = clr_ff;
            link_wdata = '0;
            mark_we    = (clr_ff < SLOT_W'(NODE_COUNT));
            mark_waddr = clr_ff[NODE_W-1:0];
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == SLOT_W'(SLOT_COUNT - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_accept) begin
               op_in        = req_op;
               last_in      = req_last;
               range_bad_in = sym_bad;
               slot_in      = link_raddr;
               if (req_empty_key) begin
                  // zero-length key: abandon the walk, look at the root
                  cur_node_in    = '0;
                  node_base_in   = '0;
                  walk_failed_in = 1'b0;
                  conc_node_in   = '0;
                  state_in       = S_MARK;
               end else begin
                  state_in = S_LINK;
               end
            end
         end

         S_LINK: begin
            // follow or allocate the child link
            if (walk_failed_ff) begin
               fail_nx = 1'b1;
            end else if (range_bad_ff) begin
               st_nx   = ST_RANGE;
               fail_nx = 1'b1;
            end else if (link_rdata != '0) begin
               node_nx = link_rdata;
            end else if (op_ff == OP_INSERT) begin
               if (next_free_ff == FREE_W'(NODE_COUNT)) begin
                  st_nx   = ST_POOL;
                  fail_nx = 1'b1;
               end else begin
                  link_we      = 1'b1;
                  node_nx      = next_free_ff[NODE_W-1:0];
                  next_free_in = next_free_ff + 1'b1;
               end
            end else begin
               fail_nx = 1'b1;
            end
            mul_node = node_nx;

            if (!last_ff) begin
               cur_node_in    = node_nx;
               node_base_in   = mul_prod;
               walk_failed_in = fail_nx;
               fin            = 1'b1;
               fin_res.status = st_nx;
            end else begin
               cur_node_in    = '0;
               node_base_in   = '0;
               walk_failed_in = 1'b0;
               if (fail_nx) begin
                  fin              = 1'b1;
                  fin_res.done_res = 1'b1;
                  fin_res.status   = st_nx;
               end else begin
                  mark_raddr   = node_nx;
                  conc_node_in = node_nx;
                  state_in     = S_MARK;
               end
            end
         end

         S_MARK: begin
            // conclude the key on its final node
            fin              = 1'b1;
            fin_res.done_res = 1'b1;
            case (op_ff)
               OP_INSERT: begin
                  mark_we        = 1'b1;
                  mark_wdata     = 1'b1;
                  fin_res.answer = 1'b1;
               end
               OP_REMOVE: begin
                  mark_we        = mark_rdata;
                  fin_res.answer = mark_rdata;
               end
               default: begin
                  fin_res.answer = mark_rdata;
               end
            endcase
         end

         S_EMIT: begin
            if (emit_ok) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // finished item: straight to the result register, or park it
      if (fin) begin
         if (emit_ok) begin
            state_in = S_IDLE;
         end else begin
            pend_in  = fin_res;
            state_in = S_EMIT;
         end
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (fin && emit_ok) begin
         rsp_valid_in = 1'b1;
         rsp_in       = fin_res;
      end else if (state_ff == S_EMIT && emit_ok) begin
         rsp_valid_in = 1'b1;
         rsp_in       = pend_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         cur_node_ff    <= '0;
         node_base_ff   <= '0;
         next_free_ff   <= FREE_W'(1);
         walk_failed_ff <= 1'b0;
         clr_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cur_node_ff    <= cur_node_in;
         node_base_ff   <= node_base_in;
         next_free_ff   <= next_free_in;
         walk_failed_ff <= walk_failed_in;
         clr_ff         <= clr_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      last_ff      <= last_in;
      range_bad_ff <= range_bad_in;
      slot_ff      <= slot_in;
      conc_node_ff <= conc_node_in;
      pend_ff      <= pend_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_done_res = rsp_ff.done_res;
   assign rsp_answer   = rsp_ff.answer;
   assign rsp_status   = rsp_ff.status;

endmodule

`default_nettype wire

@@ rtl/trie_dictionary_top.sv @@
// Trie dictionary over a fixed node pool. Keys arrive one character per item
// with an op (insert, search, remove); every item returns one result item.
// After reset a clearing pass zeroes the child link memory and the end marks,
// one entry per cycle over NODE_COUNT * ALPHABET_SIZE entries (59392 by
// default), with req_stall held high. Then each character waits on the
// registered read of the child link memory at the current node, and a
// concluding character whose walk holds adds one read of the end mark memory
// at the final node; an empty key reads only the end mark of the root.
// A waiting result is held in an output register; a second finished result
// waits until it drains. Symbols outside 'A'..'A'+ALPHABET_SIZE-1 give
// status 2, an insert with no free node gives status 1; in both cases the
// rest of the key is ignored.
// Depends on tdict_pkg, tdict_ctrl and tdict_ram.
`default_nettype none

module trie_dictionary_top import tdict_pkg::*; #(
   parameter int ALPHABET_SIZE = DEF_ALPHABET_SIZE,
   parameter int NODE_COUNT    = DEF_NODE_COUNT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [OP_W-1:0]     req_op,
   input  wire logic [SYMBOL_W-1:0] req_symbol,
   input  wire logic                req_last,
   input  wire logic                req_empty_key,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic                     rsp_done_res,
   output logic                     rsp_answer,
   output logic [STATUS_W-1:0]      rsp_status
);

   localparam int SLOT_COUNT = NODE_COUNT * ALPHABET_SIZE;
   localparam int SLOT_W     = $clog2(SLOT_COUNT);
   localparam int NODE_W     = $clog2(NODE_COUNT);

   logic              link_we;
   logic [SLOT_W-1:0] link_waddr;
   logic [NODE_W-1:0] link_wdata;
   logic [SLOT_W-1:0] link_raddr;
   logic [NODE_W-1:0] link_rdata;
   logic              mark_we;
   logic [NODE_W-1:0] mark_waddr;
   logic              mark_wdata;
   logic [NODE_W-1:0] mark_raddr;
   logic              mark_rdata;

   // Sequencer
   tdict_ctrl #(
      .ALPHABET_SIZE (ALPHABET_SIZE),
      .NODE_COUNT    (NODE_COUNT)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_op        (req_op),
      .req_symbol    (req_symbol),
      .req_last      (req_last),
      .req_empty_key (req_empty_key),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_done_res  (rsp_done_res),
      .rsp_answer    (rsp_answer),
      .rsp_status    (rsp_status),
      .link_we       (link_we),
      .link_waddr    (link_waddr),
      .link_wdata    (link_wdata),
      .link_raddr    (link_raddr),
      .link_rdata    (link_rdata),
      .mark_we       (mark_we),
      .mark_waddr    (mark_waddr),
      .mark_wdata    (mark_wdata),
      .mark_raddr    (mark_raddr),
      .mark_rdata    (mark_rdata)
   );

   // Child links, one row of ALPHABET_SIZE entries per node
   tdict_ram #(
      .DEPTH (SLOT_COUNT),
      .WIDTH (NODE_W)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_addr (link_raddr),
      .rd_data (link_rdata)
   );

   // End marks, one bit per node
   tdict_ram #(
      .DEPTH (NODE_COUNT),
      .WIDTH (1)
   ) u_mark_ram (
      .clock   (clock),
      .wr_en   (mark_we),
      .wr_addr (mark_waddr),
      .wr_data (mark_wdata),
      .rd_addr (mark_raddr),
      .rd_data (mark_rdata)
   );

endmodule

`default_nettype wire

@@ rtl/tdict_checker.sv @@
// Port-level checks of the trie dictionary, bound to trie_dictionary_top.
// Depends on tdict_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module tdict_checker import tdict_pkg::*; (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_stall,
   input wire logic                rsp_valid,
   input wire logic                rsp_stall,
   input wire logic                rsp_done_res,
   input wire logic                rsp_answer,
   input wire logic [STATUS_W-1:0] rsp_status
);

   // one item at a time: an accepted item blocks the input next cycle
   `ASSERT_NEXT(a_one_at_a_time, req_valid && !req_stall, req_stall, "item accepted twice in a row")

   // the clearing pass follows every reset
   `ASSERT_SAME(a_clear_after_reset, $fell(reset), req_stall, "input open right after reset")

   // only a concluding item carries an answer
   `ASSERT_SAME(a_answer_on_done, rsp_valid && !rsp_done_res, !rsp_answer, "answer on partial item")

   // a fault never comes with a positive answer
   `ASSERT_SAME(a_fault_no_answer, rsp_valid && (rsp_status != ST_OK), !rsp_answer, "answer with fault")

   // a stalled result item holds
   `ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_done_res) && $stable(rsp_answer) && $stable(rsp_status), "stalled item changed")

endmodule

bind trie_dictionary_top tdict_checker u_tdict_checker (.*);

`default_nettype wire
